### hdl/llsg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llsg_pkg
// Types, constants and helpers shared by the loss and gradient block.
// ---------------------------------------------------------------------------
package llsg_pkg;

	localparam int MAX_DIMS = 256;
	localparam int IW = $clog2(MAX_DIMS);
	localparam int CW = IW + 1;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_ELEM = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;
	localparam logic [1:0] REQ_CLR  = 2'd3;

	localparam logic REG_LAMBDA = 1'b0;
	localparam logic REG_DIMS   = 1'b1;

	localparam logic signed [63:0] S64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64MIN = 64'sh8000_0000_0000_0000;
	localparam logic [47:0] L1MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         elem_index;
		logic signed [31:0] elem_value;
		logic signed [31:0] label;
		logic               sample_last;
	} in_beat_t;

	typedef struct packed {
		logic signed [63:0] grad_value;
		logic [62:0]        loss_value;
		logic [7:0]         out_index;
	} out_beat_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture input beat
		logic wr_w;     // write weight, add l1
		logic mac_rd;   // read weight for mac
		logic mac;      // accumulate product
		logic res;      // form residual
		logic sq0;      // square step 0
		logic sq1;      // square step 1
		logic sq2;      // square step 2
		logic gr_rd;    // read buffered element
		logic gr_m0;    // gradient multiply 0
		logic gr_m1;    // gradient multiply 1
		logic gr_wr;    // gradient writeback
		logic rd_rd;    // read operands for result
		logic rd_m0;    // penalty multiply
		logic rd_fin;   // form result
		logic clr;      // start clear sweep
		logic clr_step; // clear one entry
	} llsg_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       inrange;
		logic       buf_room;
		logic       last;
		logic       walk_done;
		logic       clr_done;
	} llsg_sts_t;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) sadd = s[64] ? S64MIN : S64MAX;
		else sadd = s[63:0];
	endfunction

	function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) ssub = s[64] ? S64MIN : S64MAX;
		else ssub = s[63:0];
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		mag64 = a[63] ? (64'd0 - a) : a;
	endfunction

endpackage

### hdl/llsg_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llsg_datapath
// Memories, accumulators and the 32x32 multiplier steps of the block.
// ---------------------------------------------------------------------------
module llsg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  llsg_pkg::in_beat_t  in_beat,
	input  llsg_pkg::llsg_cmd_t cmd,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [30:0]         cfg_data,
	output llsg_pkg::llsg_sts_t sts,
	output llsg_pkg::out_beat_t res_beat
);
	import llsg_pkg::*;

	logic signed [31:0] weights [MAX_DIMS];
	logic signed [63:0] grad_mem [MAX_DIMS];
	logic signed [31:0] sval_mem [MAX_DIMS];
	logic [IW-1:0]      sidx_mem [MAX_DIMS];

	logic [30:0]  lambda_q;
	logic [8:0]   dims_q;
	in_beat_t     beat_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] walk_q;
	logic [IW-1:0] clr_q;
	logic signed [63:0] dot_q, loss_q;
	logic [47:0]  l1_q;

	logic signed [31:0] w_rd_q, v_rd_q;
	logic [IW-1:0]      ix_rd_q;
	logic signed [63:0] g_rd_q;
	logic signed [63:0] r_q;
	logic [63:0]        rm_q;
	logic [63:0]        p_a_q, p_b_q, p_c_q;
	logic [63:0]        pen_q;

	logic [63:0]        vmag, wmag;
	logic signed [63:0] gterm;
	logic [48:0]        l1n;
	logic [64:0]        lossn;

	logic [CW-1:0] eff_dims;
	always_comb begin
		if (dims_q == 9'd0) eff_dims = CW'(1);
		else if (32'(dims_q) > MAX_DIMS) eff_dims = CW'(MAX_DIMS);
		else eff_dims = CW'(dims_q);
	end

	assign sts.req_type  = beat_q.req_type;
	assign sts.inrange   = {1'b0, beat_q.elem_index[IW-1:0]} < eff_dims
		&& 32'(beat_q.elem_index) < MAX_DIMS;
	assign sts.buf_room  = cnt_q < CW'(MAX_DIMS);
	assign sts.last      = beat_q.sample_last;
	assign sts.walk_done = walk_q >= cnt_q;
	assign sts.clr_done  = clr_q == IW'(MAX_DIMS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= '0;
			dims_q   <= 9'd256;
		end else if (cfg_we) begin
			if (cfg_idx == REG_LAMBDA) lambda_q <= cfg_data;
			else dims_q <= cfg_data[8:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) beat_q <= in_beat;
	end

	// memory ports
	logic [IW-1:0] bix;
	assign bix = beat_q.elem_index[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_w) weights[bix] <= beat_q.elem_value;
		if (cmd.mac_rd || cmd.rd_rd) w_rd_q <= weights[bix];
		if (cmd.mac_rd) begin
			sval_mem[cnt_q[IW-1:0]] <= beat_q.elem_value;
			sidx_mem[cnt_q[IW-1:0]] <= bix;
		end
		if (cmd.gr_rd) begin
			v_rd_q  <= sval_mem[walk_q[IW-1:0]];
			ix_rd_q <= sidx_mem[walk_q[IW-1:0]];
		end
		if (cmd.rd_rd) g_rd_q <= grad_mem[bix];
		if (cmd.gr_m0) g_rd_q <= grad_mem[ix_rd_q];
		if (cmd.clr_step) grad_mem[clr_q] <= '0;
		else if (cmd.gr_wr) grad_mem[ix_rd_q] <= ssub(g_rd_q, gterm);
	end

	assign vmag = mag64(64'(v_rd_q));
	assign wmag = mag64(64'(beat_q.elem_value));

	// multiplier operand selection: one 32x32 per cycle
	logic [31:0] ma, mb;
	logic [63:0] mp;
	logic signed [63:0] sprod;
	always_comb begin
		ma = rm_q[31:0];
		mb = rm_q[31:0];
		if (cmd.sq0) begin ma = rm_q[63:32]; mb = rm_q[63:32]; end
		else if (cmd.sq1) begin ma = rm_q[31:0]; mb = rm_q[63:32]; end
		else if (cmd.gr_m0) begin ma = rm_q[31:0]; mb = vmag[31:0]; end
		else if (cmd.gr_m1) begin ma = rm_q[63:32]; mb = vmag[31:0]; end
		else if (cmd.rd_m0) begin ma = {1'b0, lambda_q}; mb = l1_q[31:0]; end
		mp = ma * mb;
	end
	assign sprod = 64'(w_rd_q) * 64'(beat_q.elem_value);

	// gradient term from partial products: lo in p_a_q, hi in mp
	logic [95:0] gfull;
	logic [80:0] gsh;
	always_comb begin
		gfull = {32'd0, p_a_q} + {mp, 32'd0};
		gsh = gfull[95:15];
		if (gsh[80:63] != '0) gterm = S64MAX;
		else gterm = signed'({1'b0, gsh[62:0]});
		if (r_q[63] != v_rd_q[31]) gterm = -gterm;
	end

	// square assembly: hh in p_b_q, lh in p_c_q, ll in mp at sq2
	logic [127:0] sqfull;
	logic [63:0]  sqv;
	always_comb begin
		sqfull = {p_b_q, 64'd0} + {31'd0, p_c_q, 33'd0} + {64'd0, mp};
		if (sqfull[127:95] != '0) sqv = 64'(S64MAX);
		else sqv = sqfull[95:32];
	end

	// penalty: lambda * l1 with l1 split lo 32 / hi 16
	logic [95:0] penfull;
	always_comb penfull = {32'd0, p_a_q} + {pen_q, 32'd0};

	assign l1n   = {1'b0, l1_q} + 49'(wmag);
	assign lossn = {1'b0, loss_q} + {1'b0, sqv};

	logic signed [63:0] res_g;
	logic [64:0] losssum;
	logic signed [63:0] lam;
	assign lam = signed'({17'd0, lambda_q, 16'd0});

	always_comb begin
		if (!sts.inrange) res_g = '0;
		else if (w_rd_q > 0) res_g = sadd(g_rd_q, lam);
		else if (w_rd_q < 0) res_g = ssub(g_rd_q, lam);
		else if (g_rd_q > lam) res_g = g_rd_q - lam;
		else if (g_rd_q < -lam) res_g = g_rd_q + lam;
		else res_g = '0;
		if (penfull[95:63] != '0) losssum = 65'(S64MAX);
		else losssum = {1'b0, loss_q} + {2'd0, penfull[62:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			walk_q   <= '0;
			clr_q    <= '0;
			dot_q    <= '0;
			loss_q   <= '0;
			l1_q     <= '0;
			r_q      <= '0;
			rm_q     <= '0;
			p_a_q    <= '0;
			p_b_q    <= '0;
			p_c_q    <= '0;
			pen_q    <= '0;
			res_beat <= '0;
		end else begin
			if (cmd.clr) begin
				cnt_q <= '0; dot_q <= '0; loss_q <= '0; l1_q <= '0; clr_q <= '0;
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.wr_w) l1_q <= (l1n > 49'(L1MAX)) ? L1MAX : l1n[47:0];
			if (cmd.mac_rd) cnt_q <= cnt_q + 1'b1;
			if (cmd.mac) dot_q <= sadd(dot_q, sprod);
			if (cmd.res) begin
				r_q  <= ssub(64'(beat_q.label) <<< 16, dot_q);
				rm_q <= mag64(ssub(64'(beat_q.label) <<< 16, dot_q));
				walk_q <= '0;
			end
			if (cmd.sq0) p_b_q <= mp;
			if (cmd.sq1) p_c_q <= mp;
			if (cmd.sq2) loss_q <= (lossn > 65'(S64MAX)) ? S64MAX : lossn[63:0];
			if (cmd.gr_m0) p_a_q <= mp;
			if (cmd.gr_wr) begin
				walk_q <= walk_q + 1'b1;
				if (sts.walk_done || walk_q + 1'b1 >= cnt_q) begin
					cnt_q <= '0; dot_q <= '0;
				end
			end
			if (cmd.res && cnt_q == '0) dot_q <= '0;
			if (cmd.rd_rd) pen_q <= 64'(lambda_q) * 64'(l1_q[47:32]);
			if (cmd.rd_m0) p_a_q <= mp;
			if (cmd.rd_fin) begin
				res_beat.grad_value <= res_g;
				res_beat.loss_value <= losssum > 65'(S64MAX) ? 63'(S64MAX) : losssum[62:0];
				res_beat.out_index  <= beat_q.elem_index;
			end
		end
	end

	ap_l1_cap: assert property (@(posedge clk) disable iff (!arst_n)
		l1_q <= L1MAX) else $error("l1 sum out of range");
	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_DIMS)) else $error("sample count overflow");
	ap_loss: assert property (@(posedge clk) disable iff (!arst_n)
		!loss_q[63]) else $error("loss went negative");
endmodule

### hdl/llsg_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llsg_ctrl
// Sequencer for load, sample, read and clear requests.
// ---------------------------------------------------------------------------
module llsg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  llsg_pkg::llsg_sts_t sts,
	output llsg_pkg::llsg_cmd_t cmd
);
	import llsg_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_DEC = 4'd1, ST_MAC = 4'd2,
		ST_RES = 4'd3, ST_SQ0 = 4'd4, ST_SQ1 = 4'd5, ST_SQ2 = 4'd6,
		ST_GRD = 4'd7, ST_GM0 = 4'd8, ST_GM1 = 4'd9, ST_GWR = 4'd10,
		ST_RM0 = 4'd11, ST_RFIN = 4'd12, ST_CLR = 4'd13, ST_RRD = 4'd14;

	logic [3:0] state_q, nxt;
	logic       ov_q;

	assign out_valid = ov_q;
	assign in_stall  = !(state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin cmd.load = 1'b1; nxt = ST_DEC; end
			end
			ST_DEC: begin
				unique case (sts.req_type)
					REQ_LOAD: begin cmd.wr_w = sts.inrange; nxt = ST_IDLE; end
					REQ_ELEM: begin
						if (sts.inrange && sts.buf_room) begin
							cmd.mac_rd = 1'b1; nxt = ST_MAC;
						end else nxt = sts.last ? ST_RES : ST_IDLE;
					end
					REQ_READ: if (!ov_q) begin cmd.rd_rd = 1'b1; nxt = ST_RRD; end
					REQ_CLR: begin cmd.clr = 1'b1; nxt = ST_CLR; end
					default: nxt = ST_IDLE;
				endcase
			end
			ST_MAC: begin cmd.mac = 1'b1; nxt = sts.last ? ST_RES : ST_IDLE; end
			ST_RES: begin cmd.res = 1'b1; nxt = ST_SQ0; end
			ST_SQ0: begin cmd.sq0 = 1'b1; nxt = ST_SQ1; end
			ST_SQ1: begin cmd.sq1 = 1'b1; nxt = ST_SQ2; end
			ST_SQ2: begin cmd.sq2 = 1'b1; nxt = ST_GRD; end
			ST_GRD: begin
				if (sts.walk_done) begin cmd.gr_wr = 1'b0; nxt = ST_IDLE; end
				else begin cmd.gr_rd = 1'b1; nxt = ST_GM0; end
			end
			ST_GM0: begin cmd.gr_m0 = 1'b1; nxt = ST_GM1; end
			ST_GM1: begin cmd.gr_m1 = 1'b1; cmd.gr_wr = 1'b1; nxt = ST_GRD; end
			ST_RRD: begin cmd.rd_m0 = 1'b1; nxt = ST_RFIN; end
			ST_RFIN: begin cmd.rd_fin = 1'b1; nxt = ST_IDLE; end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) nxt = ST_IDLE;
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// reset starts with the gradient memory sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.rd_fin) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	ap_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_fin |-> !ov_q || !out_stall) else $error("result overwritten");
	ap_clr_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> state_q == ST_CLR) else $error("clear sweep skipped");
	ap_one_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DEC) else $error("beat not decoded");
endmodule

### hdl/l1_least_squares_loss_gradient.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// l1_least_squares_loss_gradient
// L1-regularized least-squares loss and pseudo-gradient, Q32.32 accumulators.
// ---------------------------------------------------------------------------
// load and non-closing element beats pass decode and, for an element, the mac; a closing element
// adds the residual and square steps, then a gradient walk over every buffered element
// a read passes operand read, penalty multiply and result forming before its result beat is valid,
// using the shared 32x32 multiplier; a waiting result holds the next read
// a clear sweeps the gradient memory one entry a cycle
// reset clears control state and accumulators, then sweeps the gradient
// memory with in_stall high; weights stay undefined
module l1_least_squares_loss_gradient (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  llsg_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output llsg_pkg::out_beat_t out_data,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [30:0]         cfg_data
);
	import llsg_pkg::*;

	llsg_cmd_t cmd;
	llsg_sts_t sts;

	llsg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	llsg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.sts(sts), .res_beat(out_data)
	);
endmodule
